>>> rtl/core/tw3_pkg.sv
`default_nettype none

package tw3_pkg;

  // Field widths
  localparam int unsigned CmdW   = 2;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned BitIdxW = 3;
  localparam int unsigned CfgIdxW = 8;

  // Request codes
  typedef enum logic [CmdW-1:0] {
    CMD_TICK  = 2'd0,
    CMD_READ  = 2'd1,
    CMD_WRITE = 2'd2,
    CMD_RSVD  = 2'd3
  } tw3_cmd_e;

  // Register indexes
  localparam logic [CfgIdxW-1:0] REG_PHASE_TICKS = 8'd0;
  localparam logic [CfgIdxW-1:0] REG_GUARD_TICKS = 8'd1;

  // Register reset values
  localparam logic [ByteW-1:0] PHASE_TICKS_RST = 8'd2;
  localparam logic [ByteW-1:0] GUARD_TICKS_RST = 8'd4;

  // Sequencer steps, one-hot
  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_START = 9'b000000010,
    ST_WSET  = 9'b000000100,
    ST_WHIGH = 9'b000001000,
    ST_WLOW  = 9'b000010000,
    ST_RSAMP = 9'b000100000,
    ST_RHIGH = 9'b001000000,
    ST_RLOW  = 9'b010000000,
    ST_DONE  = 9'b100000000
  } tw3_state_e;

  typedef struct packed {
    logic [ByteW-1:0] phase_ticks;
    logic [ByteW-1:0] guard_ticks;
  } tw3_cfg_t;

  // One result per tick
  typedef struct packed {
    logic             chip_enable;
    logic             serial_clock;
    logic             data_out;
    logic             data_drive;
    logic             busy_res;
    logic [ByteW-1:0] read_data;
    logic             read_valid;
    logic             write_done;
  } tw3_result_t;

endpackage

`default_nettype wire

>>> rtl/core/tw3_if.sv
`default_nettype none

// Tick request channel
interface tw3_req_if;
  import tw3_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CmdW-1:0]      command;
  logic [ByteW-1:0]     command_byte;
  logic [ByteW-1:0]     write_data;
  logic                 data_in;

  modport source (output valid, command, command_byte, write_data, data_in, input ready);
  modport sink   (input valid, command, command_byte, write_data, data_in, output ready);
endinterface

// Per-tick line levels and status
interface tw3_rsp_if;
  import tw3_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 chip_enable;
  logic                 serial_clock;
  logic                 data_out;
  logic                 data_drive;
  logic                 busy_res;
  logic [ByteW-1:0]     read_data;
  logic                 read_valid;
  logic                 write_done;

  modport source (output valid, chip_enable, serial_clock, data_out, data_drive, busy_res,
                  read_data, read_valid, write_done, input ready);
  modport sink   (input valid, chip_enable, serial_clock, data_out, data_drive, busy_res,
                  read_data, read_valid, write_done, output ready);
endinterface

// Register write channel
interface tw3_cfg_if;
  import tw3_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CfgIdxW-1:0]   index;
  logic [ByteW-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> rtl/core/tw3_cfg_regs.sv
`default_nettype none

module tw3_cfg_regs (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  tw3_cfg_if.sink               cfg_i,
  output tw3_pkg::tw3_cfg_t     cfg_o
);
  import tw3_pkg::*;

  logic [ByteW-1:0] phase_ticks_q;
  logic [ByteW-1:0] guard_ticks_q;

  // Writes are always taken
  assign cfg_i.ready = 1'b1;

  // Register file; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_ticks_q <= PHASE_TICKS_RST;
      guard_ticks_q <= GUARD_TICKS_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_PHASE_TICKS: phase_ticks_q <= cfg_i.data;
        REG_GUARD_TICKS: guard_ticks_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  assign cfg_o.phase_ticks = phase_ticks_q;
  assign cfg_o.guard_ticks = guard_ticks_q;

endmodule

`default_nettype wire

>>> rtl/core/tw3_seq.sv
`default_nettype none

module tw3_seq (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          step_i,
  input  wire tw3_pkg::tw3_cfg_t             cfg_i,
  input  wire logic [tw3_pkg::CmdW-1:0]      command_i,
  input  wire logic [tw3_pkg::ByteW-1:0]     command_byte_i,
  input  wire logic [tw3_pkg::ByteW-1:0]     write_data_i,
  input  wire logic                          data_in_i,
  output tw3_pkg::tw3_result_t               result_o
);
  import tw3_pkg::*;

  tw3_state_e         state_q, state_d;
  logic [BitIdxW-1:0] bit_q, bit_d;
  logic [ByteW-1:0]   wait_q, wait_d;
  logic [ByteW-1:0]   out_shift_q, out_shift_d;
  logic [ByteW-1:0]   pending_q, pending_d;
  logic [ByteW-1:0]   in_shift_q, in_shift_d;
  logic               is_write_q, is_write_d;
  logic               second_q, second_d;

  logic [ByteW-1:0]   len;
  logic [ByteW-1:0]   len_eff;
  logic               phase_done;
  logic               cur_bit;
  tw3_cmd_e           cmd;

  assign cmd     = tw3_cmd_e'(command_i);
  assign cur_bit = out_shift_q[bit_q];

  // Phase timer: guard length around enable, phase length inside bits
  always_comb begin
    len        = ((state_q == ST_START) || (state_q == ST_DONE)) ? cfg_i.guard_ticks
                                                                 : cfg_i.phase_ticks;
    len_eff    = (len == '0) ? ByteW'(1) : len;
    phase_done = ({1'b0, wait_q} + 9'd1) >= {1'b0, len_eff};
  end

  // Next state and line levels for this tick
  always_comb begin
    state_d     = state_q;
    bit_d       = bit_q;
    wait_d      = wait_q;
    out_shift_d = out_shift_q;
    pending_d   = pending_q;
    in_shift_d  = in_shift_q;
    is_write_d  = is_write_q;
    second_d    = second_q;

    result_o              = '0;
    result_o.busy_res     = 1'b1;

    unique case (state_q)
      ST_START: begin
        result_o.chip_enable = 1'b1;
        wait_d = phase_done ? '0 : wait_q + 8'd1;
        if (phase_done) begin
          bit_d    = '0;
          second_d = 1'b0;
          state_d  = ST_WSET;
        end
      end
      ST_WSET: begin
        result_o.chip_enable = 1'b1;
        result_o.data_drive  = 1'b1;
        result_o.data_out    = cur_bit;
        wait_d = phase_done ? '0 : wait_q + 8'd1;
        if (phase_done) state_d = ST_WHIGH;
      end
      ST_WHIGH: begin
        result_o.chip_enable  = 1'b1;
        result_o.serial_clock = 1'b1;
        result_o.data_drive   = 1'b1;
        result_o.data_out     = cur_bit;
        wait_d = phase_done ? '0 : wait_q + 8'd1;
        if (phase_done) state_d = ST_WLOW;
      end
      ST_WLOW: begin
        result_o.chip_enable = 1'b1;
        result_o.data_drive  = 1'b1;
        result_o.data_out    = cur_bit;
        wait_d = phase_done ? '0 : wait_q + 8'd1;
        if (phase_done) begin
          if (bit_q != '1) begin
            bit_d   = bit_q + 3'd1;
            state_d = ST_WSET;
          end else if (!second_q && is_write_q) begin
            // command byte out, now the data byte
            out_shift_d = pending_q;
            second_d    = 1'b1;
            bit_d       = '0;
            state_d     = ST_WSET;
          end else if (!second_q) begin
            second_d = 1'b1;
            bit_d    = '0;
            state_d  = ST_RSAMP;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_RSAMP: begin
        result_o.chip_enable = 1'b1;
        in_shift_d[bit_q]    = in_shift_q[bit_q] | data_in_i;
        wait_d               = '0;
        state_d              = ST_RHIGH;
      end
      ST_RHIGH: begin
        result_o.chip_enable  = 1'b1;
        result_o.serial_clock = 1'b1;
        wait_d = phase_done ? '0 : wait_q + 8'd1;
        if (phase_done) state_d = ST_RLOW;
      end
      ST_RLOW: begin
        result_o.chip_enable = 1'b1;
        wait_d = phase_done ? '0 : wait_q + 8'd1;
        if (phase_done) begin
          if (bit_q != '1) begin
            bit_d   = bit_q + 3'd1;
            state_d = ST_RSAMP;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        wait_d = phase_done ? '0 : wait_q + 8'd1;
        if (phase_done) begin
          result_o.write_done = is_write_q;
          result_o.read_valid = !is_write_q;
          state_d             = ST_IDLE;
        end
      end
      default: begin
        // idle: start on read or write, anything else is a plain tick
        result_o.busy_res = 1'b0;
        state_d           = ST_IDLE;
        if ((cmd == CMD_READ) || (cmd == CMD_WRITE)) begin
          is_write_d  = (cmd == CMD_WRITE);
          out_shift_d = command_byte_i;
          pending_d   = write_data_i;
          if (cmd == CMD_READ) in_shift_d = '0;
          bit_d    = '0;
          wait_d   = '0;
          second_d = 1'b0;
          state_d  = ST_START;
        end
      end
    endcase

    result_o.read_data = in_shift_d;
  end

  // Sequencer state advances once per accepted tick
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      bit_q       <= '0;
      wait_q      <= '0;
      out_shift_q <= '0;
      pending_q   <= '0;
      in_shift_q  <= '0;
      is_write_q  <= 1'b0;
      second_q    <= 1'b0;
    end else if (step_i) begin
      state_q     <= state_d;
      bit_q       <= bit_d;
      wait_q      <= wait_d;
      out_shift_q <= out_shift_d;
      pending_q   <= pending_d;
      in_shift_q  <= in_shift_d;
      is_write_q  <= is_write_d;
      second_q    <= second_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/three_wire_register_access_master.sv
// A tick request's result is presented in the cycle after it is accepted.
// One tick per cycle while the result slot is free or draining; the sequencer
// step is one pass of logic from the state registers to the result register.
// Reset (rst_ni, async, active low): sequencer idle, result register empty,
// phase_ticks = 2, guard_ticks = 4.
`default_nettype none

module three_wire_register_access_master (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  tw3_req_if.sink    req_i,
  tw3_rsp_if.source  rsp_o,
  tw3_cfg_if.sink    cfg_i
);
  import tw3_pkg::*;

  tw3_cfg_t    cfg;
  tw3_result_t result;
  tw3_result_t res_q;
  logic        res_valid_q;
  logic        req_fire;

  // Take a request whenever the result slot is free or draining
  assign req_i.ready = !res_valid_q || rsp_o.ready;
  assign req_fire    = req_i.valid && req_i.ready;

  tw3_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  tw3_seq u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (req_fire),
    .cfg_i          (cfg),
    .command_i      (req_i.command),
    .command_byte_i (req_i.command_byte),
    .write_data_i   (req_i.write_data),
    .data_in_i      (req_i.data_in),
    .result_o       (result)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (req_fire) begin
      res_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      res_q <= result;
    end
  end

  assign rsp_o.valid        = res_valid_q;
  assign rsp_o.chip_enable  = res_q.chip_enable;
  assign rsp_o.serial_clock = res_q.serial_clock;
  assign rsp_o.data_out     = res_q.data_out;
  assign rsp_o.data_drive   = res_q.data_drive;
  assign rsp_o.busy_res     = res_q.busy_res;
  assign rsp_o.read_data    = res_q.read_data;
  assign rsp_o.read_valid   = res_q.read_valid;
  assign rsp_o.write_done   = res_q.write_done;

endmodule

`default_nettype wire
